@@ rtl/mct_pkg.sv @@
// ----------------------------------------------------------------------------
// mct_pkg
// Shared constants, payload types and controller commands for the
// multi-channel tachometer.
// ----------------------------------------------------------------------------
`default_nettype none

package mct_pkg;

  localparam int MOTORS   = 8;
  localparam int SAMPLES  = 10;
  localparam int PAIRS    = SAMPLES / 2;

  localparam int MOT_W    = 3;
  localparam int TS_W     = 32;
  localparam int IDX_W    = $clog2(SAMPLES);
  localparam int ADDR_W   = $clog2(MOTORS * SAMPLES);
  localparam int PCNT_W   = $clog2(PAIRS + 1);

  // sum of PAIRS differences, each below 2^32
  localparam int SUM_W    = TS_W + $clog2(PAIRS);
  localparam int PPR_W    = 8;
  localparam int DEN_W    = PPR_W + SUM_W;
  localparam int NUM_MULT = 60 * PAIRS;
  localparam int NUM_W    = TS_W + $clog2(NUM_MULT + 1);

  // quotient bits produced by the divider; magnitude clips at 2^(Q_W-1)-1
  localparam int Q_W      = 16;
  localparam int QCNT_W   = $clog2(Q_W);
  localparam int CMP_W    = DEN_W + Q_W;
  localparam int RPM_W    = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TIMER_HZ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PPR       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REV_MASK  = 2'd2;

  localparam logic [31:0] TIMER_HZ_RESET = 32'd100000000;
  localparam logic [7:0]  PPR_RESET      = 8'd7;

  localparam logic [1:0] ACT_CAPTURE = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [MOT_W-1:0] motor;
    logic [TS_W-1:0]  timestamp;
  } in_item_t;

  typedef struct packed {
    logic signed [RPM_W-1:0] rpm;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic tick;
    logic start_read;
    logic rd_a;
    logic rd_b;
    logic acc;
    logic mul;
    logic chk;
    logic div_step;
    logic out_load;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/multi_channel_tachometer_unit.sv @@
// ----------------------------------------------------------------------------
// multi_channel_tachometer_unit: per-motor period-averaging tachometer.
// Capture and tick transactions are done as soon as they are accepted; a
// read walks the ring pairs (read, read, accumulate per pair) over the single
// ring read port, scales the sum, runs 16 divider steps and loads the result.
// One transaction is in flight at a time, so no new transaction is accepted
// while a read is under way, nor while its finished result waits on out_stall.
// Synchronous reset clears the ring (per-entry valid bits), pointers and
// flags and restores register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_tachometer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input transactions
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire mct_pkg::in_item_t               in_data,
  // result transactions
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output mct_pkg::out_item_t                   out_data,
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [mct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mct_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // command bus from the sequencer into the datapath
  mct_pkg::cmd_t cmd;

  // Sequencer: decodes the action, walks the ring and steps the divider.
  mct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: ring memory, bookkeeping, pair sum, rpm math, result register.
  mct_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/mct_datapath.sv @@
// ----------------------------------------------------------------------------
// mct_datapath
// Timestamp ring memory, per-motor pointers, pair-sum accumulator,
// scaling multipliers, restoring divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mct_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire mct_pkg::cmd_t                     cmd,
  input  wire mct_pkg::in_item_t                 in_data,
  input  wire logic                              cfg_we,
  input  wire logic [mct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mct_pkg::CFG_DATA_W-1:0]    cfg_data,
  output mct_pkg::out_item_t                     out_data
);

  logic [31:0] timer_hz;
  logic [7:0]  pulses_per_rev;
  logic [7:0]  reverse_mask;

  logic [mct_pkg::TS_W-1:0]  ring_mem [mct_pkg::MOTORS*mct_pkg::SAMPLES];
  logic [mct_pkg::SAMPLES-1:0] entry_valid [mct_pkg::MOTORS];
  logic [mct_pkg::IDX_W-1:0] write_pointer [mct_pkg::MOTORS];
  logic [mct_pkg::TS_W-1:0]  last_stamp [mct_pkg::MOTORS];
  logic [mct_pkg::TS_W-1:0]  fill_stamp [mct_pkg::MOTORS];
  logic [mct_pkg::MOTORS-1:0] seen_since_tick;

  logic [mct_pkg::MOT_W-1:0] rmotor;
  logic                      motor_ok;
  logic [mct_pkg::IDX_W-1:0] idx;
  logic [mct_pkg::TS_W-1:0]  rd_data;
  logic                      rd_valid;
  logic [mct_pkg::TS_W-1:0]  a_val;
  logic [mct_pkg::SUM_W-1:0] sum;
  logic [mct_pkg::NUM_W-1:0] num;
  logic [mct_pkg::DEN_W-1:0] den;
  logic [mct_pkg::CMP_W-1:0] rem;
  logic [mct_pkg::CMP_W-1:0] dsh;
  logic [mct_pkg::Q_W-1:0]   quo;
  logic                      force_zero;
  logic                      pre_sat;

  logic                        in_ok;
  logic [mct_pkg::IDX_W-1:0]   wp_cur;
  logic [mct_pkg::ADDR_W-1:0]  wr_addr;
  logic [mct_pkg::ADDR_W-1:0]  rd_addr;
  logic [mct_pkg::TS_W-1:0]    entry;
  logic [mct_pkg::TS_W-1:0]    diff;
  logic [7:0]                  ppr_eff;
  logic [mct_pkg::CMP_W-1:0]   den_top;
  logic                        fits;
  logic                        sat_final;
  logic [mct_pkg::RPM_W-2:0]   mag;
  logic [mct_pkg::RPM_W-1:0]   mag_ext;

  function automatic logic [mct_pkg::IDX_W-1:0] idx_inc(input logic [mct_pkg::IDX_W-1:0] i);
    logic [mct_pkg::IDX_W-1:0] r;
    if (i == mct_pkg::IDX_W'(mct_pkg::SAMPLES - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  assign in_ok   = ({1'b0, in_data.motor} < (mct_pkg::MOT_W + 1)'(mct_pkg::MOTORS));
  assign wp_cur  = write_pointer[in_data.motor];
  assign wr_addr = mct_pkg::ADDR_W'(in_data.motor) * mct_pkg::ADDR_W'(mct_pkg::SAMPLES)
                 + mct_pkg::ADDR_W'(wp_cur);
  assign rd_addr = mct_pkg::ADDR_W'(rmotor) * mct_pkg::ADDR_W'(mct_pkg::SAMPLES)
                 + mct_pkg::ADDR_W'(idx);
  assign entry   = rd_valid ? rd_data : fill_stamp[rmotor];
  assign diff    = entry - a_val;
  assign ppr_eff = (pulses_per_rev == 8'd0) ? 8'd1 : pulses_per_rev;
  assign den_top = {den, mct_pkg::Q_W'(0)};
  assign fits    = (rem >= dsh);
  assign sat_final = pre_sat | quo[mct_pkg::Q_W-1];
  assign mag     = sat_final ? '1 : quo[mct_pkg::RPM_W-2:0];
  assign mag_ext = {1'b0, mag};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_hz       <= mct_pkg::TIMER_HZ_RESET;
      pulses_per_rev <= mct_pkg::PPR_RESET;
      reverse_mask   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mct_pkg::REG_TIMER_HZ: timer_hz       <= cfg_data;
        mct_pkg::REG_PPR:      pulses_per_rev <= cfg_data[7:0];
        mct_pkg::REG_REV_MASK: reverse_mask   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.capture && in_ok) begin
      ring_mem[wr_addr] <= in_data.timestamp;
    end
    rd_data <= ring_mem[rd_addr];
  end

  // per-motor bookkeeping; an invalid entry reads as the motor's fill stamp
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mct_pkg::MOTORS; i++) begin
        entry_valid[i]   <= '0;
        write_pointer[i] <= '0;
        last_stamp[i]    <= '0;
        fill_stamp[i]    <= '0;
      end
      seen_since_tick <= '0;
      rd_valid        <= 1'b0;
    end else begin
      rd_valid <= entry_valid[rmotor][idx];
      if (cmd.capture && in_ok) begin
        entry_valid[in_data.motor][wp_cur] <= 1'b1;
        write_pointer[in_data.motor]       <= idx_inc(wp_cur);
        last_stamp[in_data.motor]          <= in_data.timestamp;
        seen_since_tick[in_data.motor]     <= 1'b1;
      end
      if (cmd.tick) begin
        for (int i = 0; i < mct_pkg::MOTORS; i++) begin
          if (!seen_since_tick[i]) begin
            entry_valid[i] <= '0;
            fill_stamp[i]  <= last_stamp[i];
          end
        end
        seen_since_tick <= '0;
      end
    end
  end

  // read walk, scaling and division
  always_ff @(posedge clk) begin
    if (cmd.start_read) begin
      rmotor   <= in_data.motor;
      motor_ok <= in_ok;
      idx      <= write_pointer[in_data.motor];
      sum      <= '0;
    end
    if (cmd.rd_a || cmd.rd_b) begin
      idx <= idx_inc(idx);
    end
    if (cmd.rd_b) begin
      a_val <= entry;
    end
    if (cmd.acc) begin
      sum <= sum + mct_pkg::SUM_W'(diff);
    end
    if (cmd.mul) begin
      num <= mct_pkg::NUM_W'(timer_hz * mct_pkg::NUM_W'(mct_pkg::NUM_MULT));
      den <= mct_pkg::DEN_W'(ppr_eff) * mct_pkg::DEN_W'(sum);
    end
    if (cmd.chk) begin
      force_zero <= (sum == '0) || !motor_ok;
      pre_sat    <= (mct_pkg::CMP_W'(num) >= den_top);
      rem        <= mct_pkg::CMP_W'(num);
      dsh        <= mct_pkg::CMP_W'(den_top >> 1);
      quo        <= '0;
    end
    if (cmd.div_step) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quo <= {quo[mct_pkg::Q_W-2:0], fits};
      dsh <= dsh >> 1;
    end
    if (cmd.out_load) begin
      if (force_zero) begin
        out_data.rpm       <= '0;
        out_data.saturated <= 1'b0;
      end else begin
        out_data.rpm       <= reverse_mask[rmotor] ? -mag_ext : mag_ext;
        out_data.saturated <= sat_final;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mct_ctrl.sv @@
// ----------------------------------------------------------------------------
// mct_ctrl
// Sequencer: decodes transactions, walks the ring pairs, steps the divider
// and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mct_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_action,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mct_pkg::cmd_t           cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RA   = 3'd1;
  localparam logic [2:0] S_RB   = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]                   state;
  logic [2:0]                   state_next;
  logic [mct_pkg::PCNT_W-1:0]   pair_cnt;
  logic [mct_pkg::QCNT_W-1:0]   div_cnt;
  logic                         accept;
  logic                         last_pair;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign last_pair = (pair_cnt == mct_pkg::PCNT_W'(mct_pkg::PAIRS - 1));

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_action)
            mct_pkg::ACT_CAPTURE: cmd.capture = 1'b1;
            mct_pkg::ACT_TICK:    cmd.tick = 1'b1;
            mct_pkg::ACT_READ: begin
              cmd.start_read = 1'b1;
              state_next     = S_RA;
            end
            default: ;
          endcase
        end
      end
      S_RA: begin
        cmd.rd_a   = 1'b1;
        state_next = S_RB;
      end
      S_RB: begin
        cmd.rd_b   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = last_pair ? S_MUL : S_RA;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == '0) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pair_cnt  <= '0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.start_read) begin
        pair_cnt <= '0;
      end else if (cmd.acc) begin
        pair_cnt <= pair_cnt + 1'b1;
      end
      if (cmd.chk) begin
        div_cnt <= mct_pkg::QCNT_W'(mct_pkg::Q_W - 1);
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");

  a_walk_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && last_pair) |=> (state == S_MUL))
    else $error("pair walk did not end in scaling");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |=> (state == S_DIV && div_cnt == mct_pkg::QCNT_W'(mct_pkg::Q_W - 1)))
    else $error("divider not started correctly");
`endif

endmodule

`default_nettype wire

@@ dv/tb_multi_channel_tachometer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_multi_channel_tachometer_unit
// Drives capture, read, stall-tick and unused-code transactions and register
// writes into the tachometer, keeps its own copy of the timestamp rings and
// predicts each rpm result, which is compared field by field as it comes
// out. Both sides idle at random, and the result side holds off once, long.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_multi_channel_tachometer_unit;

  localparam int LIMIT_CYCLES = 2000000;
  // action code with no meaning; the block must ignore it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  mct_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mct_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [mct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mct_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  multi_channel_tachometer_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow state of the block
  logic [31:0] shadow_hz;
  logic [7:0]  shadow_ppr;
  logic [7:0]  shadow_rev;
  logic [31:0] shadow_ring [mct_pkg::MOTORS][mct_pkg::SAMPLES];
  int          shadow_wp [mct_pkg::MOTORS];
  logic [31:0] shadow_last [mct_pkg::MOTORS];
  bit          shadow_seen [mct_pkg::MOTORS];

  mct_pkg::out_item_t expected_rpm_q[$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;
  int  hold_off_cycles = 0;
  logic [31:0] stamp_now [mct_pkg::MOTORS];

  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic reset_shadow();
    shadow_hz = mct_pkg::TIMER_HZ_RESET;
    shadow_ppr = mct_pkg::PPR_RESET;
    shadow_rev = '0;
    for (int m = 0; m < mct_pkg::MOTORS; m++) begin
      for (int j = 0; j < mct_pkg::SAMPLES; j++) shadow_ring[m][j] = '0;
      shadow_wp[m] = 0;
      shadow_last[m] = '0;
      shadow_seen[m] = 1'b0;
      stamp_now[m] = '0;
    end
  endtask

  // rpm from the averaged period of one motor
  function automatic mct_pkg::out_item_t speed_of_motor(input int m);
    mct_pkg::out_item_t r;
    logic [63:0] period_sum, numer, denom, quot;
    logic [15:0] mag;
    int k;
    period_sum = '0;
    mag = '0;
    r.saturated = 1'b0;
    k = shadow_wp[m];
    for (int p = 0; p < mct_pkg::PAIRS; p++) begin
      period_sum += 64'(32'(shadow_ring[m][(k + 1) % mct_pkg::SAMPLES]
                            - shadow_ring[m][k]));
      k = (k + 2) % mct_pkg::SAMPLES;
    end
    if (period_sum != 0) begin
      numer = 64'(shadow_hz) * 64'(60 * mct_pkg::PAIRS);
      denom = 64'((shadow_ppr == 0) ? 8'd1 : shadow_ppr) * period_sum;
      quot = numer / denom;
      if (quot > 32767) begin
        mag = 16'd32767;
        r.saturated = 1'b1;
      end else begin
        mag = quot[15:0];
      end
    end
    r.rpm = shadow_rev[m] ? -$signed(mag) : $signed(mag);
    return r;
  endfunction

  task automatic predict(input mct_pkg::in_item_t it);
    int m;
    m = it.motor;
    case (it.action)
      mct_pkg::ACT_CAPTURE: begin
        shadow_ring[m][shadow_wp[m]] = it.timestamp;
        shadow_wp[m] = (shadow_wp[m] + 1) % mct_pkg::SAMPLES;
        shadow_last[m] = it.timestamp;
        shadow_seen[m] = 1'b1;
      end
      mct_pkg::ACT_READ: expected_rpm_q.push_back(speed_of_motor(m));
      mct_pkg::ACT_TICK: begin
        for (int i = 0; i < mct_pkg::MOTORS; i++) begin
          if (!shadow_seen[i])
            for (int j = 0; j < mct_pkg::SAMPLES; j++) shadow_ring[i][j] = shadow_last[i];
          shadow_seen[i] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  // one transaction; returns at the edge that accepted it, valid left high
  task automatic send_item(input logic [1:0] act, input logic [2:0] m,
                           input logic [31:0] ts);
    mct_pkg::in_item_t it;
    it.action = act;
    it.motor = m;
    it.timestamp = ts;
    while (sender_idles && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict(it);
  endtask

  task automatic write_reg(input logic [mct_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mct_pkg::REG_TIMER_HZ: shadow_hz = val;
      mct_pkg::REG_PPR:      shadow_ppr = val[7:0];
      mct_pkg::REG_REV_MASK: shadow_rev = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_rpm_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // a capture one random period after the last one on that motor
  task automatic capture_step(input int m, input logic [31:0] period);
    stamp_now[m] = stamp_now[m] + period;
    send_item(mct_pkg::ACT_CAPTURE, 3'(m), stamp_now[m]);
  endtask

  task automatic random_period(output logic [31:0] p);
    case ($urandom_range(5))
      0: p = $urandom();
      1: p = $urandom_range(20);
      2: p = $urandom_range(100000);
      default: p = $urandom_range(20000000, 100);
    endcase
  endtask

  task automatic test_directed();
    // empty rings: zero sum
    send_item(mct_pkg::ACT_READ, 3'd0, '0);
    send_item(mct_pkg::ACT_READ, 3'd7, '0);
    // wrapping timestamps and the extremes of the field
    send_item(mct_pkg::ACT_CAPTURE, 3'd1, 32'hFFFF_FFF0);
    send_item(mct_pkg::ACT_CAPTURE, 3'd1, 32'h0000_0010);
    send_item(mct_pkg::ACT_READ, 3'd1, '0);
    send_item(mct_pkg::ACT_CAPTURE, 3'd2, 32'h0);
    send_item(mct_pkg::ACT_CAPTURE, 3'd2, 32'hFFFF_FFFF);
    send_item(mct_pkg::ACT_READ, 3'd2, '0);
    // tiny period saturates
    send_item(mct_pkg::ACT_CAPTURE, 3'd3, 32'd5);
    send_item(mct_pkg::ACT_CAPTURE, 3'd3, 32'd6);
    send_item(mct_pkg::ACT_READ, 3'd3, '0);
    // tick fills motors 0 and 4..7, motor 3 then gets a fresh capture
    send_item(mct_pkg::ACT_TICK, 3'd0, 32'h1234_5678);
    send_item(mct_pkg::ACT_READ, 3'd1, '0);
    send_item(mct_pkg::ACT_CAPTURE, 3'd3, 32'd100);
    send_item(mct_pkg::ACT_TICK, 3'd5, '0);
    send_item(mct_pkg::ACT_READ, 3'd3, '0);
    send_item(mct_pkg::ACT_READ, 3'd2, '0);
    // unused action code is ignored
    send_item(ACT_UNUSED, 3'd6, 32'hA5A5_A5A5);
    send_item(mct_pkg::ACT_READ, 3'd6, '0);
    wait_drained();
  endtask

  task automatic test_registers();
    logic [31:0] hz_set [4] = '{32'd1, 32'hFFFF_FFFF, 32'd100000000, 32'd32768};
    logic [7:0]  ppr_set [4] = '{8'd1, 8'd255, 8'd0, 8'd7};
    logic [7:0]  rev_set [4] = '{8'hFF, 8'h00, 8'hA5, 8'h5A};
    logic [31:0] p;
    for (int s = 0; s < 4; s++) begin
      write_reg(mct_pkg::REG_TIMER_HZ, hz_set[s]);
      write_reg(mct_pkg::REG_PPR, {24'($urandom()), ppr_set[s]});
      write_reg(mct_pkg::REG_REV_MASK, {24'($urandom()), rev_set[s]});
      for (int n = 0; n < 40; n++) begin
        random_period(p);
        capture_step(n % mct_pkg::MOTORS, p);
        if (n % 3 == 0) send_item(mct_pkg::ACT_READ, 3'(n % mct_pkg::MOTORS), $urandom());
      end
      wait_drained();
    end
  endtask

  // mostly steady spinning with jitter, some noise, ticks, reads and unused codes
  task automatic test_random(input int items);
    logic [31:0] p, base [mct_pkg::MOTORS];
    int m, pick;
    for (int i = 0; i < mct_pkg::MOTORS; i++) random_period(base[i]);
    for (int n = 0; n < items; n++) begin
      m = $urandom_range(mct_pkg::MOTORS - 1);
      pick = $urandom_range(99);
      if (pick < 55) begin
        p = base[m] + $urandom_range(15);
        if ($urandom_range(30) == 0) random_period(base[m]);
        if ($urandom_range(20) == 0) random_period(p);
        capture_step(m, p);
      end else if (pick < 90) begin
        send_item(mct_pkg::ACT_READ, 3'(m), $urandom());
      end else if (pick < 97) begin
        send_item(mct_pkg::ACT_TICK, 3'(m), $urandom());
      end else begin
        send_item(ACT_UNUSED, 3'(m), $urandom());
      end
      if (n == items / 3) begin
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
      end
      if (n == items / 2) begin
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
      end
    end
    wait_drained();
  endtask

  // receiver holds off while reads keep coming, so the input backs up
  task automatic test_backpressure();
    hold_off_cycles = 300;
    for (int n = 0; n < 12; n++) send_item(mct_pkg::ACT_READ, 3'(n % mct_pkg::MOTORS), '0);
    wait_drained();
  endtask

  // result stall driver
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= receiver_idles && ($urandom_range(99) < 20);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_rpm_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        mct_pkg::out_item_t exp_r;
        exp_r = expected_rpm_q.pop_front();
        if (out_data.rpm !== exp_r.rpm)
          report_mismatch($sformatf("rpm %0d, expected %0d", out_data.rpm, exp_r.rpm));
        if (out_data.saturated !== exp_r.saturated)
          report_mismatch($sformatf("saturated %0b, expected %0b",
                                    out_data.saturated, exp_r.saturated));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    reset_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_registers();
    test_backpressure();
    test_random(1000);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/mct_pkg.sv
rtl/mct_datapath.sv
rtl/mct_ctrl.sv
rtl/multi_channel_tachometer_unit.sv
dv/tb_multi_channel_tachometer_unit.sv
